// ===== rtl/core/nmcl_pkg.sv =====
// ----------------------------------------------------------------------------
// Near-maximum candidate list: shared definitions
// Field widths, register indexes, opcodes, result kinds and reset values
// used by the candidate list unit and its parts.
// ----------------------------------------------------------------------------
`default_nettype none

package nmcl_pkg;

  // Default sizing of the list store.
  localparam int unsigned CAPACITY_DEF      = 64;
  localparam int unsigned POSITION_BITS_DEF = 24;

  // Fixed port field widths.
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned POS_OUT_W = 24;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned TOTAL_W   = 7;
  localparam int unsigned MARGIN_W  = 31;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MARGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_SCORE = 1'd1;

  // Register reset values.
  localparam logic [MARGIN_W-1:0] KEEP_MARGIN_RST = 31'd655360;
  localparam logic [SCORE_W-1:0]  START_SCORE_RST = 32'h8000_0000;

  // Input opcodes.
  localparam logic [OPCODE_W-1:0] OP_OFFER = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

endpackage : nmcl_pkg

`default_nettype wire

// ===== rtl/core/nmcl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : nmcl_ram

`default_nettype wire

// ===== rtl/core/near_max_candidate_list_unit.sv =====
// ----------------------------------------------------------------------------
// Near-maximum candidate list unit
// Keeps an ordered, bounded list of (score, position) candidates within a
// margin of the best score, prunes it on a new best, streams and clears it.
//
//   channel  | signals                                   | flow
//   ---------+-------------------------------------------+----------------------
//   command  | start_i, busy_o, opcode_i, score_i,       | taken when start_i
//            | position_i                                | and not busy_o
//   result   | res_valid_o, kind_o, entry_score_o, ...   | one-cycle strobe
//   config   | cfg_we_i, cfg_idx_i, cfg_wdata_i          | write on cfg_we_i
//
// An offer that does not beat the best score, a clear and an unused opcode
// finish in the execute state. An offer that becomes the new best adds a
// compaction pass over the N entries in the list once the offer has been
// appended (one entry read from the list RAM per cycle, survivors written
// back in place). A read-out gives one word per cycle after the first RAM
// read. The list RAM needs no clearing pass: reset only empties the count.
// The receiver cannot stall; each result word is shown for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module near_max_candidate_list_unit #(
  parameter int unsigned CAPACITY      = nmcl_pkg::CAPACITY_DEF,
  parameter int unsigned POSITION_BITS = nmcl_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Command channel.
  input  wire logic                               start_i,
  output logic                                    busy_o,
  input  wire logic [nmcl_pkg::OPCODE_W-1:0]      opcode_i,
  input  wire logic [nmcl_pkg::SCORE_W-1:0]       score_i,
  input  wire logic [nmcl_pkg::POS_OUT_W-1:0]     position_i,
  // Configuration write port.
  input  wire logic                               cfg_we_i,
  input  wire logic [nmcl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [nmcl_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // Result channel.
  output logic                                    res_valid_o,
  output logic      [nmcl_pkg::KIND_W-1:0]        kind_o,
  output logic      [nmcl_pkg::SCORE_W-1:0]       entry_score_o,
  output logic      [nmcl_pkg::POS_OUT_W-1:0]     entry_position_o,
  output logic                                    stored_o,
  output logic                                    new_best_o,
  output logic                                    overflow_o,
  output logic      [nmcl_pkg::POS_OUT_W-1:0]     best_position_o,
  output logic      [nmcl_pkg::TOTAL_W-1:0]       kept_total_o,
  output logic                                    last_o
);

  localparam int unsigned SW    = nmcl_pkg::SCORE_W;
  localparam int unsigned PW    = POSITION_BITS;
  localparam int unsigned OW    = nmcl_pkg::POS_OUT_W;
  localparam int unsigned TW    = nmcl_pkg::TOTAL_W;
  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned XW    = SW + 2;
  localparam int unsigned WORDW = SW + PW;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]                       state_q, state_d;
  logic [nmcl_pkg::OPCODE_W-1:0]    op_q, op_d;
  logic [SW-1:0]                    sc_q, sc_d;
  logic [PW-1:0]                    pos_q, pos_d;
  logic [nmcl_pkg::MARGIN_W-1:0]    margin_q;
  logic [SW-1:0]                    start_q;
  logic [SW-1:0]                    best_q, best_d;
  logic [PW-1:0]                    best_pos_q, best_pos_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    n_q, n_d;
  logic [CW-1:0]                    rptr_q, rptr_d;
  logic [CW-1:0]                    wptr_q, wptr_d;
  logic                             rvalid_q, rvalid_d;
  logic                             rlast_q, rlast_d;
  logic [XW-1:0]                    floor_q, floor_d;
  logic                             st_q, st_d;
  logic                             ov_q, ov_d;

  // Result word register.
  logic                             res_valid_q;
  logic [nmcl_pkg::KIND_W-1:0]      kind_q;
  logic [SW-1:0]                    escore_q;
  logic [PW-1:0]                    epos_q;
  logic                             stored_q, newbest_q, oflow_q, last_q;
  logic [PW-1:0]                    bpos_q;
  logic [CW-1:0]                    total_q;

  // --------------------------------------------------------------------------
  // List RAM: score in the upper bits, position in the lower bits
  // --------------------------------------------------------------------------
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [WORDW-1:0] ram_wdata, ram_rdata;
  logic [SW-1:0]    rd_score;

  nmcl_ram #(
    .Width (WORDW),
    .Depth (CAPACITY)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_score = ram_rdata[WORDW-1:PW];

  // --------------------------------------------------------------------------
  // Offer arithmetic, at 34 bits so nothing wraps
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] sc_x, best_x, margin_x, sum_x, floor_x, rd_x;
  logic                 qualify, better, keep_entry;

  assign sc_x     = {{2{sc_q[SW-1]}}, sc_q};
  assign best_x   = {{2{best_q[SW-1]}}, best_q};
  assign margin_x = {3'b000, margin_q};
  assign sum_x    = sc_x + margin_x;
  assign floor_x  = sc_x - margin_x;
  assign rd_x     = {{2{rd_score[SW-1]}}, rd_score};
  assign qualify  = sum_x > best_x;
  assign better   = $signed(sc_q) > $signed(best_q);
  assign keep_entry = rd_x > $signed(floor_q);

  // Input position masked to the stored width.
  logic [PW+OW-1:0] pos_in_ext;
  assign pos_in_ext = {{PW{1'b0}}, position_i};

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  logic                          emit;
  logic [nmcl_pkg::KIND_W-1:0]   emit_kind;
  logic [SW-1:0]                 emit_score;
  logic [PW-1:0]                 emit_pos;
  logic                          emit_st, emit_nb, emit_ov, emit_last;
  logic [PW-1:0]                 emit_bpos;
  logic [CW-1:0]                 emit_total;
  logic [CW-1:0]                 count_n;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    sc_d       = sc_q;
    pos_d      = pos_q;
    best_d     = best_q;
    best_pos_d = best_pos_q;
    count_d    = count_q;
    n_d        = n_q;
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    rvalid_d   = 1'b0;
    rlast_d    = rlast_q;
    floor_d    = floor_q;
    st_d       = st_q;
    ov_d       = ov_q;
    count_n    = count_q;

    ram_we     = 1'b0;
    ram_waddr  = wptr_q[AW-1:0];
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = rptr_q[AW-1:0];

    emit       = 1'b0;
    emit_kind  = nmcl_pkg::KIND_STATUS;
    emit_score = '0;
    emit_pos   = '0;
    emit_st    = 1'b0;
    emit_nb    = 1'b0;
    emit_ov    = 1'b0;
    emit_last  = 1'b1;
    emit_bpos  = best_pos_q;
    emit_total = count_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          sc_d    = score_i;
          pos_d   = pos_in_ext[PW-1:0];
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        case (op_q)
          nmcl_pkg::OP_OFFER: begin
            st_d = 1'b0;
            ov_d = 1'b0;
            // Append at the tail when within the margin and there is room.
            if (qualify) begin
              if (count_q < CAP_C) begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                ram_wdata = {sc_q, pos_q};
                count_n   = count_q + ONE_C;
                st_d      = 1'b1;
              end else begin
                ov_d = 1'b1;
              end
            end
            count_d = count_n;
            if (better) begin
              // New best: start the in-place compaction pass.
              best_d     = sc_q;
              best_pos_d = pos_q;
              floor_d    = floor_x;
              n_d        = count_n;
              rptr_d     = '0;
              wptr_d     = '0;
              state_d    = ST_CMP;
            end else begin
              emit       = 1'b1;
              emit_st    = st_d;
              emit_ov    = ov_d;
              emit_total = count_n;
              state_d    = ST_IDLE;
            end
          end

          nmcl_pkg::OP_READ: begin
            if (count_q == '0) begin
              emit      = 1'b1;
              emit_kind = nmcl_pkg::KIND_EMPTY;
              state_d   = ST_IDLE;
            end else begin
              n_d     = count_q;
              rptr_d  = '0;
              state_d = ST_RD;
            end
          end

          nmcl_pkg::OP_CLEAR: begin
            count_d    = '0;
            best_d     = start_q;
            best_pos_d = '0;
            emit       = 1'b1;
            emit_kind  = nmcl_pkg::KIND_EMPTY;
            emit_bpos  = '0;
            emit_total = '0;
            state_d    = ST_IDLE;
          end

          default: begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_CMP: begin
        // Read ahead of the write pointer; survivors are written back in order.
        ram_re   = rptr_q < n_q;
        rvalid_d = ram_re;
        if (ram_re) begin
          rptr_d = rptr_q + ONE_C;
        end
        if (rvalid_q && keep_entry) begin
          ram_we = 1'b1;
          wptr_d = wptr_q + ONE_C;
        end
        if (!ram_re && !rvalid_q) begin
          count_d    = wptr_q;
          emit       = 1'b1;
          emit_st    = st_q;
          emit_nb    = 1'b1;
          emit_ov    = ov_q;
          emit_total = wptr_q;
          state_d    = ST_IDLE;
        end
      end

      ST_RD: begin
        // Stream one entry per cycle behind the RAM read.
        ram_re   = rptr_q < n_q;
        rvalid_d = ram_re;
        if (ram_re) begin
          rptr_d  = rptr_q + ONE_C;
          rlast_d = rptr_q == (n_q - ONE_C);
        end
        if (rvalid_q) begin
          emit       = 1'b1;
          emit_kind  = nmcl_pkg::KIND_ENTRY;
          emit_score = rd_score;
          emit_pos   = ram_rdata[PW-1:0];
          emit_last  = rlast_q;
          if (rlast_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      best_q      <= nmcl_pkg::START_SCORE_RST;
      best_pos_q  <= '0;
      margin_q    <= nmcl_pkg::KEEP_MARGIN_RST;
      start_q     <= nmcl_pkg::START_SCORE_RST;
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      best_q      <= best_d;
      best_pos_q  <= best_pos_d;
      rvalid_q    <= rvalid_d;
      res_valid_q <= emit;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          nmcl_pkg::REG_KEEP_MARGIN: margin_q <= cfg_wdata_i[nmcl_pkg::MARGIN_W-1:0];
          nmcl_pkg::REG_START_SCORE: start_q  <= cfg_wdata_i[SW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Working payload registers.
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    sc_q    <= sc_d;
    pos_q   <= pos_d;
    n_q     <= n_d;
    rptr_q  <= rptr_d;
    wptr_q  <= wptr_d;
    rlast_q <= rlast_d;
    floor_q <= floor_d;
    st_q    <= st_d;
    ov_q    <= ov_d;
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q    <= emit_kind;
      escore_q  <= emit_score;
      epos_q    <= emit_pos;
      stored_q  <= emit_st;
      newbest_q <= emit_nb;
      oflow_q   <= emit_ov;
      bpos_q    <= emit_bpos;
      total_q   <= emit_total;
      last_q    <= emit_last;
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  logic [PW+OW-1:0] epos_ext, bpos_ext;
  logic [CW+TW-1:0] total_ext;

  assign epos_ext  = {{OW{1'b0}}, epos_q};
  assign bpos_ext  = {{OW{1'b0}}, bpos_q};
  assign total_ext = {{TW{1'b0}}, total_q};

  assign busy_o           = state_q != ST_IDLE;
  assign res_valid_o      = res_valid_q;
  assign kind_o           = kind_q;
  assign entry_score_o    = escore_q;
  assign entry_position_o = epos_ext[OW-1:0];
  assign stored_o         = stored_q;
  assign new_best_o       = newbest_q;
  assign overflow_o       = oflow_q;
  assign best_position_o  = bpos_ext[OW-1:0];
  assign kept_total_o     = total_ext[TW-1:0];
  assign last_o           = last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The list never holds more entries than the RAM has.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_C)
    else $error("list count exceeds capacity");

  // Compaction writes never pass the read pointer.
  a_wptr_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> wptr_q <= rptr_q)
    else $error("compaction write pointer ahead of read pointer");

  // A write never lands on the entry being read in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> ram_waddr != ram_raddr)
    else $error("list RAM read and write to the same entry");

  // Words that are not the last of an item only come from a read-out.
  a_multi_only_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> (state_q == ST_RD && kind_o == nmcl_pkg::KIND_ENTRY))
    else $error("non-final result word outside a read-out");

  // An offer is never both stored and dropped.
  a_store_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !(stored_o && overflow_o))
    else $error("offer reported both stored and overflow");

endmodule : near_max_candidate_list_unit

`default_nettype wire
